// ----- design/servo_pulse_slew_limiter_core_assert.svh -----
// ----------------------------------------------------------------------------
// Servo pulse slew limiter assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_SLEW_LIMITER_CORE_ASSERT_SVH
`define SERVO_PULSE_SLEW_LIMITER_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent
`define SPSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spsl assertion failed");

// Consequent must hold in the same cycle as the antecedent
`define SPSL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spsl assertion failed");

`endif

// ----- design/spsl_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo pulse slew limiter package
// Payload types, register indexes, reset values and widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spsl_pkg;

    localparam int PULSE_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_RANGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PULSE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME   = 3'd5;

    localparam logic [15:0] RST_MIN_PULSE     = 16'd500;
    localparam logic [15:0] RST_PULSE_RANGE   = 16'd2000;
    localparam logic [7:0]  RST_MAX_ANGLE     = 8'd180;
    localparam logic [15:0] RST_STEP_PULSE    = 16'd20;
    localparam logic [7:0]  RST_UPDATE_PERIOD = 8'd20;
    localparam logic [15:0] RST_SETTLE_TIME   = 16'd500;

    localparam int ANGLE_W  = 8;
    localparam int RANGE_W  = 16;
    localparam int PROD_W   = ANGLE_W + RANGE_W;
    localparam int PSUM_W   = PROD_W + 1;

    typedef struct packed {
        logic       ms_tick;
        logic       set_target;
        logic [7:0] angle;
    } t_in;

    typedef struct packed {
        logic [15:0] pulse;
        logic        at_target;
        logic        settled;
    } t_out;

endpackage

// ----- design/spsl_divider.sv -----
// ----------------------------------------------------------------------------
// Servo pulse slew limiter divider
// Restoring divider, one quotient bit per cycle, pulses done on the last bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsl_divider #(
    parameter int DIVIDEND_W = spsl_pkg::PROD_W,
    parameter int DIVISOR_W  = spsl_pkg::ANGLE_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);
    import spsl_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    shifted;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        fits    = shifted >= {1'b0, r_div};
        diff    = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- design/servo_pulse_slew_limiter_core.sv -----
// ----------------------------------------------------------------------------
// Servo pulse slew limiter core
// Target conversion, update prescaler, slew step and settle timer.
// ----------------------------------------------------------------------------
// Input beats on i_in_data carry a millisecond tick, a set request and an
// angle; every input beat yields exactly one output beat on o_out_data with
// the current compare value, an at-target flag and the settled flag.
// o_in_stall is high from the accepted beat until its result is loaded into
// the output register, so one item is worked on at a time.
// Without a set the beat passes through S_TICK and S_OUT, and the next beat
// is taken once the state is back in S_IDLE.
// With a set the angle times pulse range product goes through the restoring
// divider in S_DIV, one quotient bit per cycle, before S_SET loads the new
// target and the beat goes on through S_TICK and S_OUT. A zero max angle
// skips the divider and goes from S_MUL straight to S_SET.
// The output register holds a beat while i_out_stall is high; the next input
// beat is still taken, and its result waits until the held beat is taken.
// Register writes on the cfg channel are always ready and take effect at once.
// Reset (synchronous, active low) loads the register defaults, sets current
// and target pulse to the default minimum pulse and clears the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_pulse_slew_limiter_core #(
    parameter int PULSE_BITS = spsl_pkg::PULSE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  spsl_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output spsl_pkg::t_out               o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [spsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spsl_pkg::*;

    localparam int DW = (PULSE_BITS > 16) ? PULSE_BITS : 16;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIV, S_SET, S_TICK, S_OUT
    } t_state;

    t_state r_state;

    logic [15:0] r_min_pulse;
    logic [15:0] r_pulse_range;
    logic [7:0]  r_max_angle;
    logic [15:0] r_step_pulse;
    logic [7:0]  r_update_period;
    logic [15:0] r_settle_time;

    logic [PULSE_BITS-1:0] r_current;
    logic [PULSE_BITS-1:0] r_target;
    logic [7:0]            r_target_angle;
    logic [7:0]            r_update_count;
    logic [15:0]           r_settle_elapsed;

    logic       r_tick;
    logic [7:0] r_angle;
    logic       r_div_skip;
    logic       r_out_valid;
    t_out       r_out_data;

    logic                  in_accept;
    logic [7:0]            angle_clamped;
    logic [PROD_W-1:0]     product;
    logic                  div_start;
    logic                  div_done;
    logic [PROD_W-1:0]     div_quot;
    logic [PROD_W-1:0]     quot;
    logic [PSUM_W-1:0]     psum;
    logic                  psat;
    logic [PULSE_BITS-1:0] new_target;
    logic [7:0]            cnt_inc;
    logic                  do_upd;
    logic                  below;
    logic                  above;
    logic [PULSE_BITS-1:0] gap;
    logic [PULSE_BITS-1:0] step_p;
    logic                  big_gap;
    logic [PULSE_BITS-1:0] moved;
    logic [16:0]           settle_sum;
    logic [15:0]           settle_next;
    logic                  at_tgt;
    logic                  out_free;

    always_comb begin
        in_accept     = i_in_valid && !o_in_stall;
        angle_clamped = (i_in_data.angle > r_max_angle) ? r_max_angle : i_in_data.angle;
        product       = PROD_W'(r_angle) * PROD_W'(r_pulse_range);
        div_start     = (r_state == S_MUL) && (r_max_angle != 8'd0);
        quot          = r_div_skip ? '0 : div_quot;
        psum          = PSUM_W'(r_min_pulse) + PSUM_W'(quot);
        psat          = (PSUM_W > PULSE_BITS) && ((psum >> PULSE_BITS) != '0);
        new_target    = psat ? '1 : PULSE_BITS'(psum);
        cnt_inc       = r_update_count + 8'd1;
        do_upd        = cnt_inc >= r_update_period;
        below         = r_current < r_target;
        above         = r_current > r_target;
        gap           = below ? (r_target - r_current) : (r_current - r_target);
        step_p        = PULSE_BITS'(r_step_pulse);
        big_gap       = (r_step_pulse != 16'd0) && (DW'(gap) > DW'(r_step_pulse));
        moved         = big_gap ? (below ? r_current + step_p : r_current - step_p)
                                : r_target;
        settle_sum    = {1'b0, r_settle_elapsed} + 17'(r_update_period);
        settle_next   = (settle_sum > {1'b0, r_settle_time}) ? r_settle_time
                                                              : settle_sum[15:0];
        at_tgt        = r_current == r_target;
        out_free      = !(r_out_valid && i_out_stall);
    end

    spsl_divider #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (ANGLE_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_max_angle),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_min_pulse      <= RST_MIN_PULSE;
            r_pulse_range    <= RST_PULSE_RANGE;
            r_max_angle      <= RST_MAX_ANGLE;
            r_step_pulse     <= RST_STEP_PULSE;
            r_update_period  <= RST_UPDATE_PERIOD;
            r_settle_time    <= RST_SETTLE_TIME;
            r_current        <= PULSE_BITS'(RST_MIN_PULSE);
            r_target         <= PULSE_BITS'(RST_MIN_PULSE);
            r_target_angle   <= 8'd0;
            r_update_count   <= 8'd0;
            r_settle_elapsed <= RST_SETTLE_TIME;
            r_div_skip       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MIN_PULSE:     r_min_pulse     <= i_cfg_data;
                    CFG_PULSE_RANGE:   r_pulse_range   <= i_cfg_data;
                    CFG_MAX_ANGLE:     r_max_angle     <= i_cfg_data[7:0];
                    CFG_STEP_PULSE:    r_step_pulse    <= i_cfg_data;
                    CFG_UPDATE_PERIOD: r_update_period <= i_cfg_data[7:0];
                    CFG_SETTLE_TIME:   r_settle_time   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_tick  <= i_in_data.ms_tick;
                        r_angle <= angle_clamped;
                        r_state <= i_in_data.set_target ? S_MUL : S_TICK;
                    end
                end
                S_MUL: begin
                    r_div_skip <= r_max_angle == 8'd0;
                    r_state    <= (r_max_angle == 8'd0) ? S_SET : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SET;
                    end
                end
                S_SET: begin
                    if (!(r_target_angle == r_angle && r_target == new_target)) begin
                        r_target         <= new_target;
                        r_target_angle   <= r_angle;
                        r_settle_elapsed <= 16'd0;
                    end
                    r_state <= S_TICK;
                end
                S_TICK: begin
                    if (r_tick) begin
                        r_update_count <= do_upd ? 8'd0 : cnt_inc;
                        if (do_upd) begin
                            if (below || above) begin
                                r_current        <= moved;
                                r_settle_elapsed <= 16'd0;
                            end else if (r_settle_elapsed < r_settle_time) begin
                                r_settle_elapsed <= settle_next;
                            end
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_data.pulse     <= 16'(r_current);
                        r_out_data.at_target <= at_tgt;
                        r_out_data.settled   <= (r_target_angle == r_angle) && at_tgt &&
                                                (r_settle_elapsed >= r_settle_time);
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- design/spsl_checker.sv -----
// ----------------------------------------------------------------------------
// Servo pulse slew limiter port checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_pulse_slew_limiter_core_assert.svh"

module spsl_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  spsl_pkg::t_out i_out_data
);
    import spsl_pkg::*;

    `SPSL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `SPSL_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_data))
    `SPSL_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)
    `SPSL_ASSERT_NOW(a_settled_at_target, i_clk, i_rst_n, i_out_valid && i_out_data.settled, i_out_data.at_target)

endmodule

bind servo_pulse_slew_limiter_core spsl_checker u_spsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Servo pulse slew limiter testbench
// Drives tick/set beats through the core and checks every output beat against
// a cycle-free prediction of pulse, at-target and settled, over directed
// corner cases and randomised phases with varied register settings and
// random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import spsl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_BEATS    = 142;
    localparam int HOLD_OFF_LEN   = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    servo_pulse_slew_limiter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [15:0] reg_min_pulse;
    logic [15:0] reg_pulse_range;
    logic [7:0]  reg_max_angle;
    logic [15:0] reg_step_pulse;
    logic [7:0]  reg_update_period;
    logic [15:0] reg_settle_time;

    logic [15:0] cur_pulse;
    logic [15:0] tgt_pulse;
    logic [7:0]  tgt_angle;
    logic [7:0]  tick_count;
    logic [15:0] settle_ms;

    t_out servo_out_q[$];
    t_out want_beat;
    int   fail_count = 0;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   hold_cycles = 0;
    logic [7:0] last_angle = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void reset_servo_state();
        reg_min_pulse     = RST_MIN_PULSE;
        reg_pulse_range   = RST_PULSE_RANGE;
        reg_max_angle     = RST_MAX_ANGLE;
        reg_step_pulse    = RST_STEP_PULSE;
        reg_update_period = RST_UPDATE_PERIOD;
        reg_settle_time   = RST_SETTLE_TIME;
        cur_pulse         = RST_MIN_PULSE;
        tgt_pulse         = RST_MIN_PULSE;
        tgt_angle         = '0;
        tick_count        = '0;
        settle_ms         = RST_SETTLE_TIME;
    endfunction

    function automatic t_out next_servo_out(input t_in beat);
        logic [7:0]  ang;
        logic [31:0] quot;
        logic [31:0] psum;
        logic [15:0] new_pulse;
        logic [16:0] settle_sum;
        t_out        res;
        ang = (beat.angle > reg_max_angle) ? reg_max_angle : beat.angle;
        if (beat.set_target) begin
            quot = '0;
            if (reg_max_angle != 0)
                quot = (32'(ang) * 32'(reg_pulse_range)) / 32'(reg_max_angle);
            psum = 32'(reg_min_pulse) + quot;
            new_pulse = (psum > 32'hFFFF) ? 16'hFFFF : psum[15:0];
            if (!(tgt_angle == ang && tgt_pulse == new_pulse)) begin
                tgt_pulse = new_pulse;
                tgt_angle = ang;
                settle_ms = '0;
            end
        end
        if (beat.ms_tick) begin
            tick_count = tick_count + 8'd1;
            if (tick_count >= reg_update_period) begin
                tick_count = '0;
                if (cur_pulse < tgt_pulse) begin
                    if (reg_step_pulse != 0 && (tgt_pulse - cur_pulse) > reg_step_pulse)
                        cur_pulse = cur_pulse + reg_step_pulse;
                    else
                        cur_pulse = tgt_pulse;
                    settle_ms = '0;
                end else if (cur_pulse > tgt_pulse) begin
                    if (reg_step_pulse != 0 && (cur_pulse - tgt_pulse) > reg_step_pulse)
                        cur_pulse = cur_pulse - reg_step_pulse;
                    else
                        cur_pulse = tgt_pulse;
                    settle_ms = '0;
                end else if (settle_ms < reg_settle_time) begin
                    settle_sum = 17'(settle_ms) + 17'(reg_update_period);
                    settle_ms = (settle_sum > 17'(reg_settle_time)) ?
                                reg_settle_time : settle_sum[15:0];
                end
            end
        end
        res.pulse     = cur_pulse;
        res.at_target = (cur_pulse == tgt_pulse);
        res.settled   = (tgt_angle == ang) && res.at_target && (settle_ms >= reg_settle_time);
        return res;
    endfunction

    function automatic t_in mk_beat(input logic tick, input logic set, input logic [7:0] ang);
        t_in b;
        b.ms_tick    = tick;
        b.set_target = set;
        b.angle      = ang;
        return b;
    endfunction

    function automatic t_in random_beat();
        t_in b;
        b.ms_tick    = ($urandom_range(99) < 85);
        b.set_target = ($urandom_range(99) < 12);
        if ($urandom_range(99) < 65)
            b.angle = last_angle;
        else
            b.angle = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic send_beat(input t_in beat);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        servo_out_q.push_back(next_servo_out(beat));
        if (beat.set_target)
            last_angle = beat.angle;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (servo_out_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MIN_PULSE:     reg_min_pulse     = val;
            CFG_PULSE_RANGE:   reg_pulse_range   = val;
            CFG_MAX_ANGLE:     reg_max_angle     = val[7:0];
            CFG_STEP_PULSE:    reg_step_pulse    = val;
            CFG_UPDATE_PERIOD: reg_update_period = val[7:0];
            CFG_SETTLE_TIME:   reg_settle_time   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [15:0] min_p, input logic [15:0] range_p,
                                  input logic [7:0] max_a, input logic [15:0] step_p,
                                  input logic [7:0] period, input logic [15:0] settle_t);
        write_reg(CFG_MIN_PULSE, min_p);
        write_reg(CFG_PULSE_RANGE, range_p);
        write_reg(CFG_MAX_ANGLE, {8'h00, max_a});
        write_reg(CFG_STEP_PULSE, step_p);
        write_reg(CFG_UPDATE_PERIOD, {8'h00, period});
        write_reg(CFG_SETTLE_TIME, settle_t);
    endtask

    task automatic test_reset_defaults();
        send_beat(mk_beat(1'b0, 1'b0, 8'd0));
        send_beat(mk_beat(1'b0, 1'b0, 8'd255));
        send_beat(mk_beat(1'b1, 1'b1, 8'd90));
    endtask

    task automatic test_jump_and_clamp();
        write_reg(CFG_STEP_PULSE, 16'd0);
        write_reg(CFG_UPDATE_PERIOD, 16'd1);
        write_reg(CFG_SETTLE_TIME, 16'd0);
        send_beat(mk_beat(1'b1, 1'b1, 8'd255));
        send_beat(mk_beat(1'b1, 1'b0, 8'd180));
    endtask

    task automatic test_pulse_saturation();
        write_reg(CFG_MIN_PULSE, 16'hFFFF);
        write_reg(CFG_PULSE_RANGE, 16'hFFFF);
        write_reg(CFG_MAX_ANGLE, 16'd1);
        send_beat(mk_beat(1'b1, 1'b1, 8'd1));
        send_beat(mk_beat(1'b1, 1'b0, 8'd0));
    endtask

    task automatic test_zero_max_angle();
        write_reg(CFG_MAX_ANGLE, 16'd0);
        send_beat(mk_beat(1'b1, 1'b1, 8'd77));
        send_beat(mk_beat(1'b0, 1'b1, 8'd0));
    endtask

    task automatic test_unchanged_set();
        write_all_regs(16'd500, 16'd2000, 8'd180, 16'd1000, 8'd1, 16'd3);
        repeat (5) send_beat(mk_beat(1'b1, 1'b1, 8'd45));
        send_beat(mk_beat(1'b0, 1'b1, 8'd45));
        send_beat(mk_beat(1'b1, 1'b0, 8'd45));
    endtask

    task automatic test_zero_update_period();
        write_reg(CFG_UPDATE_PERIOD, 16'd0);
        write_reg(CFG_STEP_PULSE, 16'd7);
        send_beat(mk_beat(1'b1, 1'b1, 8'd180));
        repeat (2) send_beat(mk_beat(1'b1, 1'b0, 8'd180));
    endtask

    task automatic test_lowered_period();
        write_reg(CFG_UPDATE_PERIOD, 16'd255);
        send_beat(mk_beat(1'b1, 1'b1, 8'd0));
        repeat (3) send_beat(mk_beat(1'b1, 1'b0, 8'd0));
        write_reg(CFG_UPDATE_PERIOD, 16'd2);
        send_beat(mk_beat(1'b1, 1'b0, 8'd0));
    endtask

    task automatic test_unused_index();
        write_reg(CFG_UNUSED_LO, 16'($urandom_range(65535)));
        write_reg(CFG_UNUSED_HI, 16'($urandom_range(65535)));
        send_beat(mk_beat(1'b1, 1'b0, 8'd0));
    endtask

    task automatic test_random_phase(input int phase);
        snd_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 78 : 0;
        rcv_idle_pct = (phase < 2) ? 78 : (phase < 4) ? 23 : 0;
        case (phase)
            1: write_all_regs(16'd0, 16'hFFFF, 8'd255, 16'hFFFF, 8'd1, 16'hFFFF);
            5: write_all_regs(16'd0, 16'd0, 8'd1, 16'd1, 8'd1, 16'd0);
            4: write_all_regs(16'($urandom_range(65535, 60000)), 16'($urandom_range(65535)),
                              8'($urandom_range(255, 1)), 16'($urandom_range(4000, 1)),
                              8'($urandom_range(3, 1)), 16'($urandom_range(40)));
            default: write_all_regs(16'($urandom_range(2000)), 16'($urandom_range(3000)),
                                    8'($urandom_range(255, 1)), 16'($urandom_range(400, 1)),
                                    8'($urandom_range(3, 1)), 16'($urandom_range(60)));
        endcase
        for (int n = 0; n < PHASE_BEATS; n++) begin
            if (phase == 1 && n == 40)
                hold_cycles = HOLD_OFF_LEN;
            if (phase == 3 && n == 70)
                wait_idle();
            send_beat(random_beat());
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (servo_out_q.size() == 0) begin
                $error("output beat with no result pending: pulse %0d", o_out_data.pulse);
                fail_count++;
            end else begin
                want_beat = servo_out_q.pop_front();
                if (o_out_data.pulse !== want_beat.pulse) begin
                    $error("pulse: expected %0d, got %0d", want_beat.pulse, o_out_data.pulse);
                    fail_count++;
                end
                if (o_out_data.at_target !== want_beat.at_target) begin
                    $error("at_target: expected %0b, got %0b",
                           want_beat.at_target, o_out_data.at_target);
                    fail_count++;
                end
                if (o_out_data.settled !== want_beat.settled) begin
                    $error("settled: expected %0b, got %0b",
                           want_beat.settled, o_out_data.settled);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        reset_servo_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle_pct = 23;
        rcv_idle_pct = 78;
        test_reset_defaults();
        test_jump_and_clamp();
        test_pulse_saturation();
        test_zero_max_angle();
        test_unchanged_set();
        test_zero_update_period();
        test_lowered_period();
        test_unused_index();
        for (int p = 0; p < 6; p++)
            test_random_phase(p);
        wait_idle();
        if (fail_count == 0 && servo_out_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/spsl_pkg.sv
design/spsl_divider.sv
design/servo_pulse_slew_limiter_core.sv
design/spsl_checker.sv
tb/tb_top.sv
